### rtl/core/bld_pkg.sv
// Shared types, constants and tables for the boiler link frame deframer.
package bld_pkg;

  // Frame delimiters and limits.
  localparam logic [7:0]  START_BYTE = 8'h68;
  localparam logic [7:0]  END_BYTE   = 8'h16;
  localparam logic [15:0] MIN_LENGTH = 16'd10;

  // Measurement words carried by a data frame.
  localparam int MEASURE_COUNT = 8;
  localparam int CNT_W         = $clog2(MEASURE_COUNT + 1);
  localparam int IDX_W         = 3;

  // First byte position of each measurement word (data base plus offset).
  localparam logic [15:0] WORD_START [MEASURE_COUNT] = '{
    16'd86, 16'd102, 16'd106, 16'd110, 16'd118, 16'd122, 16'd94, 16'd256
  };

  // Smallest frame length for which the whole word lies before the checksum.
  localparam logic [15:0] WORD_LIMIT [MEASURE_COUNT] = '{
    16'd92, 16'd108, 16'd112, 16'd116, 16'd124, 16'd128, 16'd100, 16'd262
  };

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_LEN     = 2'd0;
  localparam logic [1:0] REG_SENDER_TYPE = 2'd1;
  localparam logic [1:0] REG_DATA_TYPE   = 2'd2;

  // Result kinds.
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_WORD    = 1'b1;

  // Frame status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_SIZE     = 2'd2
  } status_t;

  // Receiver phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [15:0] max_len;
    logic [7:0]  sender_type;
    logic [7:0]  data_type;
  } cfg_t;

  // Frame event raised by the parser for one processed byte.
  typedef struct packed {
    logic        emit;
    logic        words;
    status_t     status;
    logic [7:0]  frame_type;
    logic [7:0]  recipient;
    logic [7:0]  sender_addr;
    logic [7:0]  version;
    logic [15:0] frame_length;
  } event_t;

  // Measurement store as a packed block of words.
  typedef logic [MEASURE_COUNT-1:0][31:0] words_t;

  // One result row held in the output register.
  typedef struct packed {
    logic             kind;
    status_t          status;
    logic [7:0]       frame_type;
    logic [7:0]       recipient;
    logic [7:0]       sender_addr;
    logic [7:0]       version;
    logic [15:0]      frame_length;
    logic [IDX_W-1:0] measure_index;
    logic [31:0]      measure_bits;
    logic             last;
  } row_t;

endpackage

### rtl/core/bld_parser.sv
// Byte-level frame parser: receiver phase, header capture, checksum and measurement store.
module bld_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  bld_pkg::cfg_t         cfg,
  output logic                  may_emit,
  output bld_pkg::event_t       ev,
  output bld_pkg::words_t       store,
  output logic [15:0]           frame_length
);
  import bld_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  rcp_r, rcp_nxt;
  logic [7:0]  snd_r, snd_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [7:0]  prev_r, prev_nxt;
  words_t      store_r, store_nxt;

  logic        body_data;
  logic        body_end;
  logic        size_bad;
  status_t     sum_status;

  // Position tests against the length field, widened to avoid wrap.
  assign body_data = ({1'b0, pos_r} + 17'd2) < {1'b0, len_r};
  assign body_end  = ({1'b0, pos_r} + 17'd1) >= {1'b0, len_r};
  assign size_bad  = (len_r > cfg.max_len) || (len_r < MIN_LENGTH);
  assign sum_status = (xor_r == prev_r) ? ST_OK : ST_CHECKSUM;

  // A result can only come from the last header byte or the last body byte.
  assign may_emit = ((phase_r == PH_HEAD) && (pos_r >= 16'd6)) ||
                    ((phase_r == PH_BODY) && body_end);

  assign store        = store_r;
  assign frame_length = len_r;

  // Next state and frame event for the byte being processed.
  always_comb begin
    logic [15:0] diff;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    rcp_nxt   = rcp_r;
    snd_nxt   = snd_r;
    ver_nxt   = ver_r;
    ftype_nxt = ftype_r;
    prev_nxt  = prev_r;
    store_nxt = store_r;
    diff      = '0;
    ev        = '0;
    ev.frame_length = len_r;
    ev.recipient    = rcp_r;
    ev.sender_addr  = snd_r;
    ev.version      = ver_r;
    if (step) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == START_BYTE) begin
            store_nxt = '0;
            rcp_nxt   = '0;
            snd_nxt   = '0;
            ver_nxt   = '0;
            ftype_nxt = '0;
            len_nxt   = '0;
            xor_nxt   = rx_byte;
            pos_nxt   = 16'd1;
            phase_nxt = PH_HEAD;
          end
        end
        PH_SKIP: begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end
        PH_HEAD: begin
          xor_nxt = xor_r ^ rx_byte;
          pos_nxt = pos_r + 16'd1;
          if (pos_r == 16'd1) begin
            len_nxt = {8'h00, rx_byte};
          end else if (pos_r == 16'd2) begin
            len_nxt = {rx_byte, len_r[7:0]};
          end else if (pos_r == 16'd3) begin
            rcp_nxt = rx_byte;
          end else if (pos_r == 16'd4) begin
            snd_nxt = rx_byte;
          end else if (pos_r == 16'd5) begin
            if (rx_byte != cfg.sender_type) begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            // Version byte closes the header; the length is checked here.
            ver_nxt = rx_byte;
            if (size_bad) begin
              ev.emit       = 1'b1;
              ev.status     = ST_SIZE;
              ev.frame_type = '0;
              ev.version    = rx_byte;
              phase_nxt     = PH_HUNT;
              pos_nxt       = '0;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (pos_r == 16'd7) begin
            ftype_nxt = rx_byte;
          end
          // Bytes before the checksum feed the XOR and the measurement store.
          if (body_data) begin
            xor_nxt = xor_r ^ rx_byte;
            for (int k = 0; k < MEASURE_COUNT; k++) begin
              diff = pos_r - WORD_START[k];
              if ((pos_r >= WORD_START[k]) && (diff < 16'd4)) begin
                store_nxt[k][{diff[1:0], 3'b000} +: 8] = rx_byte;
              end
            end
          end
          if (body_end) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
            if (rx_byte == END_BYTE) begin
              ev.emit       = 1'b1;
              ev.status     = sum_status;
              ev.frame_type = ftype_r;
              ev.words      = (sum_status == ST_OK) && (ftype_r == cfg.data_type);
            end
          end else begin
            prev_nxt = rx_byte;
            pos_nxt  = pos_r + 16'd1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      rcp_r   <= '0;
      snd_r   <= '0;
      ver_r   <= '0;
      ftype_r <= '0;
      prev_r  <= '0;
      store_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      rcp_r   <= rcp_nxt;
      snd_r   <= snd_nxt;
      ver_r   <= ver_nxt;
      ftype_r <= ftype_nxt;
      prev_r  <= prev_nxt;
      store_r <= store_nxt;
    end
  end

endmodule

### rtl/core/boiler_link_frame_deframer.sv
// Top level of the boiler link frame deframer: input register, parser and result sequencer.
//
// Received bytes enter on the in_ stream, one byte per transaction. Each byte is
// held in an input register until the parser processes it, and the block
// takes one byte every cycle while no result is waiting.
// Results leave on the out_ stream from a result register: a frame summary
// (tuser 0) for every frame of the configured sender type that ends with a valid
// delimiter or fails the size check, followed on a good data frame by eight
// measurement words (tuser 1). tlast marks the final result caused by one byte.
// A summary passes through the input register and then the result register.
// While the eight words of a data frame are sent, one per cycle while the receiver
// takes them, the parser holds and in_tready falls once the input register holds a
// byte; a byte that cannot cause a result still passes while an earlier result
// waits to be taken. When the receiver stalls, the result register holds its
// transaction and in_tready stays low once the held byte may raise a result.
// Reset puts the parser in its hunting phase, empties both registers and loads
// the configuration defaults: maximum length 1024, sender type 0xFC and data
// frame type 0x08. The cfg_ channel is always ready.
module boiler_link_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: tdata = rx_byte[7:0].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result stream: tdata = status[1:0], frame_type[9:2], recipient[17:10],
  // sender_addr[25:18], version[33:26], frame_length[49:34],
  // measure_index[52:50], measure_bits[84:53], zero fill[87:85].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,
  // Result stream: tuser = kind[0].
  output logic        out_tuser,
  output logic        out_tlast,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bld_pkg::*;

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  row_t              row_r, row_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  widx_r, widx_nxt;

  logic              out_free;
  logic              may_emit;
  logic              step;
  event_t            ev;
  words_t            store;
  logic [15:0]       frame_length;
  logic              word_ok;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_len     <= 16'd1024;
      cfg_r.sender_type <= 8'hFC;
      cfg_r.data_type   <= 8'h08;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_LEN:     cfg_r.max_len     <= cfg_data;
        REG_SENDER_TYPE: cfg_r.sender_type <= cfg_data[7:0];
        REG_DATA_TYPE:   cfg_r.data_type   <= cfg_data[7:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // The held byte is processed once no words are pending and any result it
  // might raise has room in the result register.
  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && (cnt_r == '0) && (out_free || !may_emit);
  assign in_tready = !s1_valid_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  bld_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (s1_byte_r),
    .cfg          (cfg_r),
    .may_emit     (may_emit),
    .ev           (ev),
    .store        (store),
    .frame_length (frame_length)
  );

  // A word's bits are reported only if all four bytes lie before the checksum.
  assign word_ok = frame_length >= WORD_LIMIT[widx_r];

  // Result sequencer: a summary from the parser, then the pending words.
  always_comb begin
    out_valid_nxt = out_valid_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    widx_nxt      = widx_r;
    if (step && ev.emit) begin
      out_valid_nxt        = 1'b1;
      row_nxt              = '0;
      row_nxt.kind         = KIND_SUMMARY;
      row_nxt.status       = ev.status;
      row_nxt.frame_type   = ev.frame_type;
      row_nxt.recipient    = ev.recipient;
      row_nxt.sender_addr  = ev.sender_addr;
      row_nxt.version      = ev.version;
      row_nxt.frame_length = ev.frame_length;
      row_nxt.last         = !ev.words;
      if (ev.words) begin
        cnt_nxt  = CNT_W'(MEASURE_COUNT);
        widx_nxt = '0;
      end
    end else if ((cnt_r != '0) && out_free) begin
      out_valid_nxt         = 1'b1;
      row_nxt               = '0;
      row_nxt.kind          = KIND_WORD;
      row_nxt.status        = ST_OK;
      row_nxt.measure_index = widx_r;
      row_nxt.measure_bits  = word_ok ? store[widx_r] : 32'd0;
      row_nxt.last          = (cnt_r == CNT_W'(1));
      cnt_nxt               = cnt_r - CNT_W'(1);
      widx_nxt              = widx_r + IDX_W'(1);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Result register and sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      widx_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      widx_r      <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  // Port packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = row_r.kind;
  assign out_tlast  = row_r.last;
  assign out_tdata  = {3'b000, row_r.measure_bits, row_r.measure_index,
                       row_r.frame_length, row_r.version, row_r.sender_addr,
                       row_r.recipient, row_r.frame_type, row_r.status};

endmodule
